### src/rkhp_pkg.sv
`timescale 1ns / 1ps

package rkhp_pkg;

	localparam int HASH_W = 64;
	localparam int CNT_W  = 13;
	localparam int IDX_W  = 12;
	localparam int BIT_W  = 6;

	localparam logic [HASH_W-1:0] FNV_BASIS = 64'hCBF29CE484222325;

	localparam logic [7:0] BYTE_NL  = 8'd10;
	localparam logic [7:0] BYTE_TAB = 8'd9;

	// tabs before the fifth field, and the saturation point of the counter
	localparam logic [2:0] KEY_TABS = 3'd4;
	localparam logic [2:0] TABS_SAT = 3'd5;

	localparam logic [CNT_W-1:0] PART_CNT_RESET = 13'd256;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SHORT = 2'd1,
		ST_FIFTH = 2'd2
	} line_status_t;

	typedef struct packed {
		logic [HASH_W-1:0] hash;
		line_status_t      status;
	} line_rec_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_HOLD
	} back_state_t;

	// one fnv-1a round; prime is 2^40 + 0x1b3, built from shifts and adds
	function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
		input logic [7:0] b);
		logic [HASH_W-1:0] x;
		x = h ^ {{(HASH_W-8){1'b0}}, b};
		return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

endpackage

### src/rkhp_front.sv
`timescale 1ns / 1ps

module rkhp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [7:0]          in_byte,
	output logic                in_ready,
	input  logic                q_full,
	output logic                q_push,
	output rkhp_pkg::line_rec_t q_rec
);

	logic [rkhp_pkg::HASH_W-1:0] hash_q;
	logic [rkhp_pkg::HASH_W-1:0] hash_nxt;
	logic [2:0]                  tabs_q;
	logic                        has_bytes_q;
	logic                        fifth_q;
	logic                        in_fire;
	logic                        is_nl;
	logic                        is_tab;
	rkhp_pkg::line_status_t      status;

	assign in_ready = !q_full;
	assign in_fire  = in_valid && in_ready;
	assign is_nl    = (in_byte == rkhp_pkg::BYTE_NL);
	assign is_tab   = (in_byte == rkhp_pkg::BYTE_TAB);
	assign hash_nxt = rkhp_pkg::fnv_step(hash_q, in_byte);

	always_comb begin
		if (tabs_q < rkhp_pkg::KEY_TABS) begin
			status = rkhp_pkg::ST_SHORT;
		end else if (tabs_q == rkhp_pkg::KEY_TABS || !fifth_q) begin
			status = rkhp_pkg::ST_FIFTH;
		end else begin
			status = rkhp_pkg::ST_OK;
		end
	end

	assign q_push       = in_fire && is_nl && has_bytes_q;
	assign q_rec.hash   = hash_q;
	assign q_rec.status = status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q      <= rkhp_pkg::FNV_BASIS;
			tabs_q      <= '0;
			has_bytes_q <= 1'b0;
			fifth_q     <= 1'b0;
		end else if (in_fire) begin
			if (is_nl) begin
				hash_q      <= rkhp_pkg::FNV_BASIS;
				tabs_q      <= '0;
				has_bytes_q <= 1'b0;
				fifth_q     <= 1'b0;
			end else begin
				has_bytes_q <= 1'b1;
				if (is_tab) begin
					// only the first three tabs belong to the key
					if (tabs_q < rkhp_pkg::KEY_TABS - 3'd1) begin
						hash_q <= hash_nxt;
					end
					if (tabs_q < rkhp_pkg::TABS_SAT) begin
						tabs_q <= tabs_q + 3'd1;
					end
				end else begin
					if (tabs_q < rkhp_pkg::KEY_TABS) begin
						hash_q <= hash_nxt;
					end else if (tabs_q == rkhp_pkg::KEY_TABS) begin
						fifth_q <= 1'b1;
					end
				end
			end
		end
	end

endmodule

### src/rkhp_fifo.sv
`timescale 1ns / 1ps

module rkhp_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  rkhp_pkg::line_rec_t push_rec,
	output logic                full,
	input  logic                pop,
	output rkhp_pkg::line_rec_t pop_rec,
	output logic                not_empty
);

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	rkhp_pkg::line_rec_t mem_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [PTR_W:0]      fill_q;

	assign full      = (fill_q == (PTR_W+1)'(DEPTH));
	assign not_empty = (fill_q != '0);
	assign pop_rec   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

### src/rkhp_back.sv
`timescale 1ns / 1ps

module rkhp_back #(
	parameter int DIV_W = 13
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_valid,
	input  rkhp_pkg::line_rec_t                 q_rec,
	output logic                                q_pop,
	input  logic [DIV_W-1:0]                    divisor,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [rkhp_pkg::IDX_W-1:0]          out_index,
	output rkhp_pkg::line_status_t              out_status
);

	localparam int EXT_W = (DIV_W > rkhp_pkg::IDX_W) ? DIV_W : rkhp_pkg::IDX_W;
	localparam logic [rkhp_pkg::BIT_W-1:0] LAST_BIT = rkhp_pkg::BIT_W'(rkhp_pkg::HASH_W - 1);

	rkhp_pkg::back_state_t       state_q;
	rkhp_pkg::back_state_t       state_nxt;
	logic [rkhp_pkg::HASH_W-1:0] dvd_q;
	logic [DIV_W-1:0]            rem_q;
	logic [DIV_W-1:0]            div_q;
	logic [DIV_W-1:0]            rem_nxt;
	logic [DIV_W:0]              trial;
	logic [rkhp_pkg::BIT_W-1:0]  bit_q;
	rkhp_pkg::line_status_t      stat_q;
	logic [EXT_W-1:0]            rem_ext;
	logic                        load_out;
	logic                        out_valid_q;
	logic [rkhp_pkg::IDX_W-1:0]  idx_q;
	rkhp_pkg::line_status_t      out_stat_q;

	// one restoring step per cycle, msb of the hash first
	assign trial   = {rem_q, dvd_q[rkhp_pkg::HASH_W-1]};
	assign rem_nxt = (trial >= {1'b0, div_q}) ? DIV_W'(trial - {1'b0, div_q})
		: trial[DIV_W-1:0];
	assign rem_ext = EXT_W'(rem_q);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			rkhp_pkg::BK_IDLE: begin
				if (q_valid) begin
					state_nxt = (q_rec.status == rkhp_pkg::ST_OK) ? rkhp_pkg::BK_DIV
						: rkhp_pkg::BK_HOLD;
				end
			end
			rkhp_pkg::BK_DIV: begin
				if (bit_q == LAST_BIT) begin
					state_nxt = rkhp_pkg::BK_HOLD;
				end
			end
			rkhp_pkg::BK_HOLD: begin
				if (!out_valid_q || out_ready) begin
					state_nxt = rkhp_pkg::BK_IDLE;
				end
			end
			default: state_nxt = rkhp_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			rkhp_pkg::BK_IDLE: q_pop    = q_valid;
			rkhp_pkg::BK_HOLD: load_out = !out_valid_q || out_ready;
			default: begin
				q_pop    = 1'b0;
				load_out = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rkhp_pkg::BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			dvd_q  <= q_rec.hash;
			rem_q  <= '0;
			bit_q  <= '0;
			div_q  <= divisor;
			stat_q <= q_rec.status;
		end else if (state_q == rkhp_pkg::BK_DIV) begin
			dvd_q <= dvd_q << 1;
			rem_q <= rem_nxt;
			bit_q <= bit_q + 1'b1;
		end
		if (load_out) begin
			idx_q      <= rem_ext[rkhp_pkg::IDX_W-1:0];
			out_stat_q <= stat_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_index  = idx_q;
	assign out_status = out_stat_q;

endmodule

### src/record_key_hash_partitioner.sv
`timescale 1ns / 1ps
// channel  | signals                       | payload
// ---------+-------------------------------+-----------------------------------------
// s_       | s_tvalid s_tready s_tdata[7:0] | text_byte
// m_       | m_tvalid m_tready m_tdata[15:0]| [11:0] partition_index, [13:12] line_status
// cfg_     | cfg_valid cfg_ready cfg_data   | partition_count (13 bits)
//
// bytes are taken one per cycle while the line queue (four lines) has room
// an ok line passes the bit-serial remainder unit (one hash bit a cycle) between pop
// and output load; a failed line goes from pop straight to output load
// arst_n clears the line state, queue, remainder unit and output; count resets to 256
// a stalled m_ side backs up the queue, then s_tready drops

module record_key_hash_partitioner #(
	parameter int MAX_PARTITIONS = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] text_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [11:0] partition_index, [13:12] line_status, [15:14] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [12:0] cfg_data
);

	localparam int DIV_W = $clog2(MAX_PARTITIONS + 1);
	localparam int EW    = (DIV_W > rkhp_pkg::CNT_W) ? DIV_W : rkhp_pkg::CNT_W;

	logic [rkhp_pkg::CNT_W-1:0]  part_cnt_q;
	logic [EW-1:0]               cnt_ext;
	logic [EW-1:0]               div_ext;
	logic [DIV_W-1:0]            divisor;
	logic                        q_push;
	logic                        q_full;
	logic                        q_pop;
	logic                        q_valid;
	rkhp_pkg::line_rec_t         push_rec;
	rkhp_pkg::line_rec_t         pop_rec;
	logic [rkhp_pkg::IDX_W-1:0]  out_index;
	rkhp_pkg::line_status_t      out_status;

	// register write request, always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_cnt_q <= rkhp_pkg::PART_CNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			part_cnt_q <= cfg_data;
		end
	end

	// zero count acts as one, anything above the maximum is clamped
	assign cnt_ext = EW'(part_cnt_q);
	always_comb begin
		if (cnt_ext == '0) begin
			div_ext = EW'(1);
		end else if (cnt_ext > EW'(MAX_PARTITIONS)) begin
			div_ext = EW'(MAX_PARTITIONS);
		end else begin
			div_ext = cnt_ext;
		end
	end
	assign divisor = div_ext[DIV_W-1:0];

	// front: hashes key bytes and classifies each line
	rkhp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_byte  (s_tdata),
		.in_ready (s_tready),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_rec    (push_rec)
	);

	// finished lines wait here for the remainder unit
	rkhp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_rec  (push_rec),
		.full      (q_full),
		.pop       (q_pop),
		.pop_rec   (pop_rec),
		.not_empty (q_valid)
	);

	// back: hash modulo partition count, output register
	rkhp_back #(
		.DIV_W (DIV_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_rec      (pop_rec),
		.q_pop      (q_pop),
		.divisor    (divisor),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_index  (out_index),
		.out_status (out_status)
	);

	assign m_tdata = {2'b00, out_status, out_index};

`ifndef NO_ASSERTIONS
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[13:12] == rkhp_pkg::ST_OK || m_tdata[13:12] == rkhp_pkg::ST_SHORT
		|| m_tdata[13:12] == rkhp_pkg::ST_FIFTH))
		else $error("bad line status on output");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[13:12] != rkhp_pkg::ST_OK) |-> (m_tdata[11:0] == '0))
		else $error("failed line carries nonzero index");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[13:12] == rkhp_pkg::ST_OK) |-> (EW'(m_tdata[11:0]) < div_ext))
		else $error("partition index not below divisor");
`endif

endmodule

### tb/tb_record_key_hash_partitioner.sv
`timescale 1ns / 1ps

module tb_record_key_hash_partitioner;

	localparam int            MAX_PART  = 4096;
	localparam logic [63:0]   FNV_PRIME = 64'd1099511628211;
	// an ok line still runs through the remainder unit after its newline; leave margin
	localparam int            SETTLE_CYC = 100;
	localparam int            LONG_HOLD  = 1200;
	localparam int            PHASE_BYTES = 195;

	typedef struct {
		logic [rkhp_pkg::IDX_W-1:0] idx;
		rkhp_pkg::line_status_t     status;
	} part_result_t;

	typedef enum int {
		RK_GOOD,
		RK_EMPTY,
		RK_SHORT,
		RK_FIFTH_EMPTY,
		RK_OPEN_FIFTH,
		RK_NOISE
	} rec_kind_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;   // [7:0] text_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;          // [11:0] partition_index, [13:12] line_status
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [12:0] cfg_data = 13'd0;

	record_key_hash_partitioner #(
		.MAX_PARTITIONS(MAX_PART)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// line hashing state kept by the testbench
	logic [rkhp_pkg::HASH_W-1:0] key_hash       = rkhp_pkg::FNV_BASIS;
	logic [2:0]                  tabs_seen      = 3'd0;
	logic                        line_has_bytes = 1'b0;
	logic                        fifth_nonempty = 1'b0;
	logic [rkhp_pkg::CNT_W-1:0]  part_count     = rkhp_pkg::PART_CNT_RESET;

	part_result_t part_expect_q[$];
	logic [7:0]   text_q[$];

	int          err_cnt    = 0;
	int          n_queued   = 0;
	int          n_accepted = 0;
	int unsigned send_gap   = 0;
	int unsigned rx_gap     = 0;
	int unsigned hold_left  = 0;
	bit          s_idle_on  = 1'b1;
	bit          m_idle_on  = 1'b1;
	bit          stall_toggle = 1'b0;
	bit          stall_seen   = 1'b0;
	logic        byte_taken   = 1'b0;
	logic        result_taken = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic clear_line();
		key_hash       = rkhp_pkg::FNV_BASIS;
		tabs_seen      = 3'd0;
		line_has_bytes = 1'b0;
		fifth_nonempty = 1'b0;
	endtask

	// one accepted byte; a newline of a non-empty line yields one partition result
	task automatic absorb_text_byte(input logic [7:0] b);
		logic [63:0]  div;
		part_result_t r;
		if (b == rkhp_pkg::BYTE_NL) begin
			if (line_has_bytes) begin
				if (tabs_seen < rkhp_pkg::KEY_TABS)
					r.status = rkhp_pkg::ST_SHORT;
				else if (tabs_seen == rkhp_pkg::KEY_TABS || !fifth_nonempty)
					r.status = rkhp_pkg::ST_FIFTH;
				else
					r.status = rkhp_pkg::ST_OK;
				r.idx = '0;
				if (r.status == rkhp_pkg::ST_OK) begin
					// zero divisor acts as one, oversize clamps to the max
					if (part_count == 0)
						div = 64'd1;
					else if (part_count > MAX_PART)
						div = 64'(MAX_PART);
					else
						div = {51'd0, part_count};
					r.idx = rkhp_pkg::IDX_W'(key_hash % div);
				end
				part_expect_q = {part_expect_q, r};
			end
			clear_line();
		end else begin
			line_has_bytes = 1'b1;
			if (b == rkhp_pkg::BYTE_TAB) begin
				// the fourth tab closes the key and is not hashed
				if (tabs_seen + 1 < rkhp_pkg::KEY_TABS)
					key_hash = (key_hash ^ {56'd0, b}) * FNV_PRIME;
				if (tabs_seen < rkhp_pkg::TABS_SAT)
					tabs_seen = tabs_seen + 3'd1;
			end else if (tabs_seen < rkhp_pkg::KEY_TABS) begin
				key_hash = (key_hash ^ {56'd0, b}) * FNV_PRIME;
			end else if (tabs_seen == rkhp_pkg::KEY_TABS) begin
				fifth_nonempty = 1'b1;
			end
		end
	endtask

	// sample handshakes, run the predictor and check results
	always @(posedge clk) begin
		part_result_t exp_r;
		byte_taken   <= s_tvalid && s_tready;
		result_taken <= m_tvalid && m_tready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				part_count = cfg_data;
			if (s_tvalid && s_tready) begin
				absorb_text_byte(s_tdata);
				n_accepted++;
			end
			if (m_tvalid && m_tready) begin
				if (part_expect_q.size() == 0) begin
					$error("unexpected result: partition_index %0d line_status %0d",
						m_tdata[11:0], m_tdata[13:12]);
					err_cnt++;
				end else begin
					exp_r = part_expect_q.pop_front();
					if (m_tdata[11:0] !== exp_r.idx) begin
						$error("partition_index: expected %0d, got %0d",
							exp_r.idx, m_tdata[11:0]);
						err_cnt++;
					end
					if (m_tdata[13:12] !== exp_r.status) begin
						$error("line_status: expected %0d, got %0d",
							exp_r.status, m_tdata[13:12]);
						err_cnt++;
					end
				end
			end
		end
	end

	// byte sender: holds a request until taken, then waits its drawn gap
	always @(negedge clk) begin
		if (arst_n && !(s_tvalid && !byte_taken)) begin
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (text_q.size() > 0) begin
				s_tdata  <= text_q.pop_front();
				s_tvalid <= 1'b1;
				send_gap = s_idle_on ? $urandom_range(0, 7) : 0;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result receiver: per-result stall, plus one long hold-off on request
	always @(negedge clk) begin
		if (stall_toggle != stall_seen) begin
			stall_seen = stall_toggle;
			hold_left  = LONG_HOLD;
		end
		if (result_taken)
			rx_gap = m_idle_on ? $urandom_range(0, 7) : 0;
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic push_byte(input logic [7:0] b);
		text_q = {text_q, b};
		n_queued++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	// any byte that is neither a tab nor a newline
	function automatic logic [7:0] field_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (b == rkhp_pkg::BYTE_TAB || b == rkhp_pkg::BYTE_NL)
			b = b ^ 8'h80;
		return b;
	endfunction

	task automatic push_run(input int lo, input int hi);
		int n;
		n = $urandom_range(lo, hi);
		repeat (n) push_byte(field_byte());
	endtask

	task automatic push_fields(input int count, input int lo, input int hi);
		repeat (count) begin
			push_run(lo, hi);
			push_byte(rkhp_pkg::BYTE_TAB);
		end
	endtask

	task automatic push_record(input rec_kind_t kind);
		int n;
		case (kind)
			RK_GOOD: begin
				push_fields(4, 0, 5);
				push_fields(1, 1, 4);
				if ($urandom_range(0, 3) == 0) begin
					// trailing fields, tabs past the fifth included
					n = $urandom_range(1, 8);
					repeat (n) push_byte($urandom_range(0, 2) == 0 ? rkhp_pkg::BYTE_TAB
						: field_byte());
				end
			end
			RK_SHORT: begin
				push_fields($urandom_range(0, 3), 0, 5);
				push_run(1, 5);
			end
			RK_FIFTH_EMPTY: begin
				push_fields(4, 0, 5);
				if ($urandom_range(0, 1)) begin
					push_byte(rkhp_pkg::BYTE_TAB);
					push_run(0, 4);
				end
			end
			RK_OPEN_FIFTH: begin
				push_fields(4, 0, 5);
				push_run(1, 4);
			end
			RK_NOISE: begin
				n = $urandom_range(1, 12);
				repeat (n) begin
					case ($urandom_range(0, 7))
						0:       push_byte(rkhp_pkg::BYTE_TAB);
						1:       push_byte(rkhp_pkg::BYTE_NL);
						default: push_byte(8'($urandom_range(0, 255)));
					endcase
				end
			end
			default: ;
		endcase
		push_byte(rkhp_pkg::BYTE_NL);
	endtask

	function automatic rec_kind_t pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 72)      return RK_GOOD;
		else if (r < 76) return RK_EMPTY;
		else if (r < 83) return RK_SHORT;
		else if (r < 89) return RK_FIFTH_EMPTY;
		else if (r < 95) return RK_OPEN_FIFTH;
		else             return RK_NOISE;
	endfunction

	// all bytes taken and all results back, then let the block settle
	task automatic wait_drained();
		while (n_accepted != n_queued || part_expect_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	task automatic write_part_count(input logic [12:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [12:0] count_plan[9];
		int          start_cnt;
		count_plan = '{13'd256, 13'd1, 13'd4096, 13'd0, 13'd8191, 13'd4097, 13'd3,
			13'd0, 13'd0};
		count_plan[7] = 13'($urandom_range(1, 4096));
		count_plan[8] = 13'($urandom_range(0, 8191));

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed lines at the reset partition count
		@(posedge clk);
		push_byte(rkhp_pkg::BYTE_NL);        // empty line, no result
		push_text("\t\t\t\tx\t\n");          // empty key fields
		push_byte(8'h00);                    // extreme key bytes, extra tabs
		push_byte(8'hFF);
		push_text("\t\t\t\tz\t\t\t\n");
		push_text("ab\n");                   // too few fields
		push_text("\t\t\t\t\n");             // fifth field empty
		push_text("\t\t\tk\tq\n");           // fifth field not closed by a tab
		wait_drained();

		for (int ph = 0; ph < 9; ph++) begin
			if (ph != 0)
				write_part_count(count_plan[ph]);
			s_idle_on = (ph % 3) != 0;
			m_idle_on = (ph % 2) == 0;
			@(posedge clk);
			start_cnt = n_queued;
			if (ph == 2) begin
				// receiver stalls long while bytes keep coming, so the block backs up
				s_idle_on    = 1'b0;
				stall_toggle = ~stall_toggle;
			end
			if (ph == 4) begin
				// sender stops mid-line until every result is back
				push_fields(2, 1, 3);
				wait_drained();
				@(posedge clk);
				push_fields(2, 0, 3);
				push_fields(1, 1, 3);
				push_byte(rkhp_pkg::BYTE_NL);
			end
			while (n_queued - start_cnt < PHASE_BYTES)
				push_record(pick_kind());
			wait_drained();
		end

		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
